>>> hdl/cpe_pkg.sv
// shared types and constants of the combination pair enumerator
package cpe_pkg;

	localparam int IDX_W   = 6;
	localparam int FIELD_W = 48;
	localparam int FIELD_POS = 8;
	localparam int SIZE_W  = 4;
	localparam int CNT_W   = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SUBSET_SIZE  = 2'd0,
		REG_FIRST_COUNT  = 2'd1,
		REG_SECOND_COUNT = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic load;
		logic adv;
		logic restart;
	} step_t;

endpackage

>>> hdl/combination_pair_enumerator_core.sv
// top level of the combination pair enumerator
//
// Walks every pair of k-subsets (A from n1 elements, B from n2 elements) in
// nested lexicographic order, B varying fastest. Each request on the s_ side
// emits the current pair on the m_ side and advances the walk by one pair.
// s_tdata bit 0 is the restart flag: when set, both subsets go back to
// 0..k-1 before the pair is emitted. m_tlast marks the pair after which
// both subsets wrap; the next request starts the walk over.
// Configuration (subset size, both set sizes) is written on the cfg channel,
// which is always ready; the user must write it only while no request is in
// flight, which the block itself does not enforce. Latency: the result is
// valid the cycle after the request is accepted. Throughput: one pair per
// cycle while the receiver keeps up; the raise search and the refill ripple
// across the row of position cells are combinational. When the receiver
// stalls, the result holds in the output register and s_tready drops until
// it is taken. Reset puts both subsets at 0..k-1 and the config registers at 1; no clearing pass is needed.
module combination_pair_enumerator_core #(
	parameter int MAX_SUBSET = 8,
	parameter int MAX_SET    = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // restart
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [2*cpe_pkg::FIELD_W-1:0]     m_tdata,   // first_indices, second_indices
	output logic                              m_tlast,   // last_pair
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cpe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cpe_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam logic [cpe_pkg::SIZE_W-1:0] K_MAX = cpe_pkg::SIZE_W'(MAX_SUBSET);
	localparam logic [cpe_pkg::CNT_W-1:0]  N_MAX = cpe_pkg::CNT_W'(MAX_SET);

	logic [cpe_pkg::SIZE_W-1:0] subset_size_q;
	logic [cpe_pkg::CNT_W-1:0]  first_count_q;
	logic [cpe_pkg::CNT_W-1:0]  second_count_q;
	logic [cpe_pkg::SIZE_W-1:0] k;
	logic [cpe_pkg::CNT_W-1:0]  n1;
	logic [cpe_pkg::CNT_W-1:0]  n2;

	logic                          accept;
	logic                          restart;
	logic                          wrap1;
	logic                          wrap2;
	logic [cpe_pkg::FIELD_W-1:0]   first_idx;
	logic [cpe_pkg::FIELD_W-1:0]   second_idx;
	cpe_pkg::step_t                step1;
	cpe_pkg::step_t                step2;

	logic                          out_valid_q;
	logic [2*cpe_pkg::FIELD_W-1:0] out_data_q;
	logic                          out_last_q;

	// config registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subset_size_q  <= cpe_pkg::SIZE_W'(1);
			first_count_q  <= cpe_pkg::CNT_W'(1);
			second_count_q <= cpe_pkg::CNT_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cpe_pkg::REG_SUBSET_SIZE: begin
					subset_size_q <= cfg_data[cpe_pkg::SIZE_W-1:0];
				end
				cpe_pkg::REG_FIRST_COUNT: begin
					first_count_q <= cfg_data;
				end
				cpe_pkg::REG_SECOND_COUNT: begin
					second_count_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign k  = (subset_size_q > K_MAX) ? K_MAX : subset_size_q;
	assign n1 = (first_count_q > N_MAX) ? N_MAX : first_count_q;
	assign n2 = (second_count_q > N_MAX) ? N_MAX : second_count_q;

	// request handling
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign restart  = s_tdata[0];

	assign step2 = '{load: accept, adv: 1'b1, restart: restart};
	assign step1 = '{load: accept, adv: wrap2, restart: restart};

	cpe_chain #(.MAX_SUBSET(MAX_SUBSET)) u_first (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step1),
		.k       (k),
		.n       (n1),
		.wrap    (wrap1),
		.indices (first_idx)
	);

	cpe_chain #(.MAX_SUBSET(MAX_SUBSET)) u_second (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step2),
		.k       (k),
		.n       (n2),
		.wrap    (wrap2),
		.indices (second_idx)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {second_idx, first_idx};
			out_last_q <= wrap2 && wrap1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid)
		else $error("accepted request produced no result");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tlast)))
		else $error("stalled result was overwritten");

	a_last_needs_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !wrap2) |=> !m_tlast)
		else $error("last pair flagged without second subset wrap");

	a_restart_first: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && restart) |=> (m_tdata[cpe_pkg::IDX_W-1:0] == '0))
		else $error("restart did not emit the first pair");

endmodule

>>> hdl/cpe_cell.sv
// one position of a sorted index list, with its raise test and refill step
module cpe_cell #(
	parameter int POS = 0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cpe_pkg::step_t                 step,
	input  logic                           wrap,
	input  logic [cpe_pkg::SIZE_W-1:0]     k,
	input  logic [cpe_pkg::CNT_W-1:0]      n,
	input  logic                           raise_in,
	output logic                           raise_out,
	input  logic [cpe_pkg::IDX_W-1:0]      left_next,
	output logic [cpe_pkg::IDX_W-1:0]      next_value,
	output logic [cpe_pkg::IDX_W-1:0]      cur_value
);

	localparam logic [cpe_pkg::IDX_W-1:0] POS_VAL = cpe_pkg::IDX_W'(POS);

	logic [cpe_pkg::IDX_W-1:0] value_q;
	logic                      in_use;
	logic                      can_raise;

	assign cur_value = step.restart ? POS_VAL : value_q;
	assign in_use    = 8'(POS) < 8'(k);
	// a < n - k + pos, kept unsigned
	assign can_raise = in_use && ((8'(cur_value) + 8'(k)) < (8'(n) + 8'(POS)));
	assign raise_out = raise_in | can_raise;

	always_comb begin
		priority if (!in_use) begin
			next_value = cur_value;
		end else if (wrap) begin
			next_value = POS_VAL;
		end else if (raise_in) begin
			next_value = cur_value;
		end else if (can_raise) begin
			next_value = cur_value + 1'b1;
		end else begin
			next_value = left_next + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= POS_VAL;
		end else if (step.load) begin
			value_q <= step.adv ? next_value : cur_value;
		end
	end

endmodule

>>> hdl/cpe_chain.sv
// row of position cells holding one subset, with packing of the index list
module cpe_chain #(
	parameter int MAX_SUBSET = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cpe_pkg::step_t                 step,
	input  logic [cpe_pkg::SIZE_W-1:0]     k,
	input  logic [cpe_pkg::CNT_W-1:0]      n,
	output logic                           wrap,
	output logic [cpe_pkg::FIELD_W-1:0]    indices
);

	localparam int PACK_POS = (MAX_SUBSET < cpe_pkg::FIELD_POS) ? MAX_SUBSET
		: cpe_pkg::FIELD_POS;

	logic                      raise [MAX_SUBSET+1];
	logic [cpe_pkg::IDX_W-1:0] nxt   [MAX_SUBSET];
	logic [cpe_pkg::IDX_W-1:0] cur   [MAX_SUBSET];

	assign raise[MAX_SUBSET] = 1'b0;
	assign wrap = !raise[0];

	for (genvar i = 0; i < MAX_SUBSET; i++) begin : g_cell
		logic [cpe_pkg::IDX_W-1:0] left;
		if (i == 0) begin : g_head
			assign left = '0;
		end else begin : g_body
			assign left = nxt[i-1];
		end
		cpe_cell #(.POS(i)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.step       (step),
			.wrap       (wrap),
			.k          (k),
			.n          (n),
			.raise_in   (raise[i+1]),
			.raise_out  (raise[i]),
			.left_next  (left),
			.next_value (nxt[i]),
			.cur_value  (cur[i])
		);
	end

	always_comb begin
		indices = '0;
		for (int i = 0; i < PACK_POS; i++) begin
			if (8'(i) < 8'(k)) begin
				indices[i*cpe_pkg::IDX_W +: cpe_pkg::IDX_W] = cur[i];
			end
		end
	end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// testbench of the combination pair enumerator core: streamed requests checked against a predictor
module tb;

	typedef struct packed {
		logic [cpe_pkg::FIELD_W-1:0] first;
		logic [cpe_pkg::FIELD_W-1:0] second;
		logic                        last;
	} pair_t;

	typedef struct packed {
		cpe_pkg::cfg_reg_t              idx;
		logic [cpe_pkg::CFG_DATA_W-1:0] value;
	} reg_write_t;

	typedef logic [cpe_pkg::FIELD_POS-1:0][cpe_pkg::IDX_W-1:0] combo_t;

	localparam int SUBSET_CAP   = 8;
	localparam int SET_CAP      = 64;
	localparam int STALL_LIMIT  = 1000;
	localparam int RANDOM_ITEMS = 850;

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [7:0]                       s_tdata;   // restart
	logic                             m_tvalid;
	logic                             m_tready;
	logic [2*cpe_pkg::FIELD_W-1:0]    m_tdata;   // first_indices, second_indices
	logic                             m_tlast;   // last_pair
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [cpe_pkg::CFG_IDX_W-1:0]    cfg_index;
	logic [cpe_pkg::CFG_DATA_W-1:0]   cfg_data;

	logic       restart_queue[$];
	reg_write_t reg_write_queue[$];
	pair_t      pending_pairs[$];

	combo_t                     combo_a;
	combo_t                     combo_b;
	logic [cpe_pkg::SIZE_W-1:0] size_reg;
	logic [cpe_pkg::CNT_W-1:0]  count_a;
	logic [cpe_pkg::CNT_W-1:0]  count_b;

	int  send_idle_pct;
	int  recv_idle_pct;
	int  mismatch_count = 0;
	int  quiet_cycles = 0;
	bit  req_fire = 1'b0;
	bit  res_fire = 1'b0;
	bit  cfg_fire = 1'b0;

	combination_pair_enumerator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic combo_t start_combo();
		combo_t c;
		for (int i = 0; i < cpe_pkg::FIELD_POS; i++) c[i] = cpe_pkg::IDX_W'(i);
		return c;
	endfunction

	function automatic int eff_size();
		return (size_reg > SUBSET_CAP) ? SUBSET_CAP : int'(size_reg);
	endfunction

	function automatic int eff_count(input logic [cpe_pkg::CNT_W-1:0] n);
		return (n > SET_CAP) ? SET_CAP : int'(n);
	endfunction

	// raise the rightmost position that can still grow, refill after it; 0 on wrap
	function automatic bit raise_subset(inout combo_t c, input int n, input int k);
		bit raised;
		raised = 1'b0;
		if (k <= 0) return 1'b0;
		for (int i = k - 1; i >= 0 && !raised; i--) begin
			if (int'(c[i]) < n - k + i) begin
				c[i] = c[i] + 1'b1;
				for (int j = i + 1; j < k; j++) c[j] = c[j-1] + 1'b1;
				raised = 1'b1;
			end
		end
		if (!raised)
			for (int i = 0; i < k; i++) c[i] = cpe_pkg::IDX_W'(i);
		return raised;
	endfunction

	function automatic logic [cpe_pkg::FIELD_W-1:0] pack_subset(input combo_t c, input int k);
		logic [cpe_pkg::FIELD_W-1:0] v;
		v = '0;
		for (int i = 0; i < k; i++) v[cpe_pkg::IDX_W*i +: cpe_pkg::IDX_W] = c[i];
		return v;
	endfunction

	function automatic pair_t next_pair(input logic restart);
		pair_t p;
		int    k;
		bit    wrap_a;
		bit    wrap_b;
		k = eff_size();
		wrap_a = 1'b0;
		if (restart) begin
			combo_a = start_combo();
			combo_b = start_combo();
		end
		p.first  = pack_subset(combo_a, k);
		p.second = pack_subset(combo_b, k);
		wrap_b = !raise_subset(combo_b, eff_count(count_b), k);
		if (wrap_b) wrap_a = !raise_subset(combo_a, eff_count(count_a), k);
		p.last = wrap_a && wrap_b;
		return p;
	endfunction

	// request and config driver, receiver ready
	always @(negedge clk) begin
		if (arst_n) begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
			if (!s_tvalid || req_fire) begin
				if (restart_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					s_tdata  <= {7'b0, restart_queue.pop_front()};
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			if (!cfg_valid || cfg_fire) begin
				if (reg_write_queue.size() != 0) begin
					cfg_index <= reg_write_queue[0].idx;
					cfg_data  <= reg_write_queue[0].value;
					cfg_valid <= 1'b1;
					void'(reg_write_queue.pop_front());
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	// monitor, predictor update and watchdog
	always @(posedge clk) begin
		pair_t want;
		if (arst_n) begin
			req_fire = s_tvalid && s_tready;
			res_fire = m_tvalid && m_tready;
			cfg_fire = cfg_valid && cfg_ready;
			if (res_fire) begin
				if (pending_pairs.size() == 0) begin
					$error("pair with no request pending");
					mismatch_count++;
				end else begin
					want = pending_pairs.pop_front();
					if (m_tdata[cpe_pkg::FIELD_W-1:0] !== want.first) begin
						$error("first_indices: expected %h, got %h", want.first,
							m_tdata[cpe_pkg::FIELD_W-1:0]);
						mismatch_count++;
					end
					if (m_tdata[2*cpe_pkg::FIELD_W-1:cpe_pkg::FIELD_W] !== want.second) begin
						$error("second_indices: expected %h, got %h", want.second,
							m_tdata[2*cpe_pkg::FIELD_W-1:cpe_pkg::FIELD_W]);
						mismatch_count++;
					end
					if (m_tlast !== want.last) begin
						$error("last_pair: expected %b, got %b", want.last, m_tlast);
						mismatch_count++;
					end
				end
			end
			if (req_fire) pending_pairs.push_back(next_pair(s_tdata[0]));
			if (cfg_fire) begin
				unique case (cfg_index)
					cpe_pkg::REG_SUBSET_SIZE:  size_reg = cfg_data[cpe_pkg::SIZE_W-1:0];
					cpe_pkg::REG_FIRST_COUNT:  count_a = cfg_data;
					cpe_pkg::REG_SECOND_COUNT: count_b = cfg_data;
					default: ;
				endcase
			end
			if (req_fire || res_fire || cfg_fire) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("Verification failed");
					$finish;
				end
			end
		end
	end

	task automatic wait_idle();
		while (restart_queue.size() != 0 || s_tvalid || pending_pairs.size() != 0 ||
				reg_write_queue.size() != 0 || cfg_valid)
			@(negedge clk);
	endtask

	task automatic write_reg(input cpe_pkg::cfg_reg_t idx,
			input logic [cpe_pkg::CFG_DATA_W-1:0] value);
		reg_write_t w;
		w.idx = idx;
		w.value = value;
		reg_write_queue.push_back(w);
	endtask

	task automatic set_regs(input logic [cpe_pkg::CFG_DATA_W-1:0] k,
			input logic [cpe_pkg::CFG_DATA_W-1:0] n1,
			input logic [cpe_pkg::CFG_DATA_W-1:0] n2);
		wait_idle();
		write_reg(cpe_pkg::REG_SUBSET_SIZE, k);
		write_reg(cpe_pkg::REG_FIRST_COUNT, n1);
		write_reg(cpe_pkg::REG_SECOND_COUNT, n2);
		wait_idle();
	endtask

	task automatic add_items(input int count, input int restart_pct);
		for (int i = 0; i < count; i++)
			restart_queue.push_back($urandom_range(0, 99) < restart_pct);
	endtask

	initial begin
		int random_done;
		int r;
		int k;
		int count;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		m_tready  = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = cpe_pkg::REG_SUBSET_SIZE;
		cfg_data  = '0;
		combo_a   = start_combo();
		combo_b   = start_combo();
		size_reg  = 4'd1;
		count_a   = 7'd1;
		count_b   = 7'd1;
		send_idle_pct = 17;
		recv_idle_pct = 50;
		random_done = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: single-element sets, every pair is last
		restart_queue.push_back(1'b0);
		restart_queue.push_back(1'b0);
		restart_queue.push_back(1'b1);
		wait_idle();
		// empty subsets
		write_reg(cpe_pkg::REG_SUBSET_SIZE, 7'd0);
		wait_idle();
		add_items(2, 0);
		// oversized subset and set sizes get clamped
		set_regs(7'h7F, 7'h7F, 7'h7F);
		add_items(3, 0);
		// first set empty, smaller than k
		set_regs(7'd3, 7'd0, 7'd5);
		restart_queue.push_back(1'b0);
		restart_queue.push_back(1'b1);
		restart_queue.push_back(1'b0);
		// full walk through the last pair and over the wrap
		set_regs(7'd2, 7'd3, 7'd3);
		restart_queue.push_back(1'b1);
		add_items(9, 0);
		wait_idle();
		// bound changed mid walk
		write_reg(cpe_pkg::REG_SECOND_COUNT, 7'd2);
		wait_idle();
		add_items(3, 0);

		while (random_done < RANDOM_ITEMS) begin
			if (random_done < RANDOM_ITEMS / 3) begin
				send_idle_pct = 17;
				recv_idle_pct = 50;
			end else if (random_done < 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 50;
				recv_idle_pct = 17;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			wait_idle();
			r = $urandom_range(0, 99);
			if (r < 60) begin
				k = $urandom_range(1, 3);
				set_regs(cpe_pkg::CFG_DATA_W'(k),
					cpe_pkg::CFG_DATA_W'($urandom_range(k, k + 2)),
					cpe_pkg::CFG_DATA_W'($urandom_range(k, k + 2)));
			end else if (r < 70) begin
				write_reg(cpe_pkg::cfg_reg_t'($urandom_range(0, 2)),
					cpe_pkg::CFG_DATA_W'($urandom_range(0, 127)));
				wait_idle();
			end else if (r < 80) begin
				k = $urandom_range(0, 15);
				set_regs(cpe_pkg::CFG_DATA_W'(k | ($urandom_range(0, 7) << 4)),
					cpe_pkg::CFG_DATA_W'($urandom_range(0, k)),
					cpe_pkg::CFG_DATA_W'($urandom_range(0, k)));
			end else begin
				set_regs(cpe_pkg::CFG_DATA_W'($urandom_range(0, 127)),
					cpe_pkg::CFG_DATA_W'($urandom_range(0, 127)),
					cpe_pkg::CFG_DATA_W'($urandom_range(0, 127)));
			end
			count = $urandom_range(20, 70);
			add_items(count, 4);
			random_done += count;
		end

		wait_idle();
		repeat (4) @(negedge clk);
		if (mismatch_count == 0 && pending_pairs.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
